// File: hdl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types, codes and default sizes for the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // Default sizes of the node store and of the stored code.
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_CODE_BITS = 16;

    // Field widths fixed by the command interface.
    localparam int CMD_W    = 2;
    localparam int CLS_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [CLS_W-1:0]    cls_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes.
    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_PEEK   = 2'd1;
    localparam cmd_t CMD_POP    = 2'd2;

    // Priority classes; a lower number is served first.
    localparam cls_t CLS_VIP    = 2'd0;
    localparam cls_t CLS_CLIENT = 2'd1;
    localparam cls_t CLS_NORMAL = 2'd2;
    localparam int   NUM_CLS    = 3;

    // Status codes.
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

// File: hdl/tcpq_ram.sv
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/three_class_priority_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Strict priority queue with three classes and FIFO order inside each class.
// ----------------------------------------------------------------------------
// The result strobe is registered from the execute state that follows the start
// transfer; busy is high in that state, so no new command is taken until it ends.
// The execute state waits on the registered read of the link and code memories,
// which are read on the start transfer and written back in the following cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// After reset the queue is empty and ready at once; no clearing pass is run.
module three_class_priority_queue #(
    parameter int CAPACITY  = tcpq_pkg::DEF_CAPACITY,
    parameter int CODE_BITS = tcpq_pkg::DEF_CODE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tcpq_pkg::CMD_W-1:0]       cmd,
    input  logic [CODE_BITS-1:0]             item_code,
    input  logic [tcpq_pkg::CLS_W-1:0]       item_class,
    output logic                             done,
    output logic [tcpq_pkg::STATUS_W-1:0]    status,
    output logic [CODE_BITS-1:0]             head_code,
    output logic [tcpq_pkg::CLS_W-1:0]       head_class,
    output logic [$clog2(CAPACITY+1)-1:0]    occupancy
);

    import tcpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer and captured command.
    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [CODE_BITS-1:0] code_reg;
    cls_t                cls_reg;

    // Queue bookkeeping.
    logic [AW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] hwm_reg, hwm_next;
    logic [CW-1:0] count_reg, count_next;
    logic [NUM_CLS-1:0] present_reg, present_next;
    logic [AW-1:0] head_reg [NUM_CLS];
    logic [AW-1:0] head_next [NUM_CLS];
    logic [AW-1:0] tail_reg [NUM_CLS];
    logic [AW-1:0] tail_next [NUM_CLS];

    // Result registers.
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [CODE_BITS-1:0] head_code_reg, head_code_next;
    cls_t                 head_class_reg, head_class_next;

    // Memory ports.
    logic                 accept;
    cls_t                 in_cls;
    cls_t                 sel_cls;
    logic [AW-1:0]        link_raddr;
    logic [AW-1:0]        link_rdata;
    logic                 link_we;
    logic [AW-1:0]        link_waddr;
    logic [AW-1:0]        link_wdata;
    logic                 code_we;
    logic [CODE_BITS-1:0] code_rdata;
    logic                 fresh;
    logic [AW-1:0]        fresh_next;

    assign busy       = (state_reg == S_EXEC);
    assign accept     = start && !busy;
    assign done       = done_reg;
    assign status     = status_reg;
    assign head_code  = head_code_reg;
    assign head_class = head_class_reg;
    assign occupancy  = count_reg;

    // A class code beyond the last class is taken as normal.
    assign in_cls = (item_class > CLS_NORMAL) ? CLS_NORMAL : item_class;

    // The head of the queue is the head of the highest present class.
    always_comb
    begin
        priority if (present_reg[CLS_VIP])
        begin
            sel_cls = CLS_VIP;
        end
        else if (present_reg[CLS_CLIENT])
        begin
            sel_cls = CLS_CLIENT;
        end
        else
        begin
            sel_cls = CLS_NORMAL;
        end
    end

    // An insert reads the free-list link, a peek or pop the queue link.
    assign link_raddr = (cmd == CMD_INSERT) ? free_head_reg : head_reg[sel_cls];

    // Nodes at or above the high-water mark were never used; their free-list
    // successor is the next index, wrapping at the end of the store.
    assign fresh      = (CW'(free_head_reg) == hwm_reg);
    assign fresh_next = (free_head_reg == AW'(CAPACITY - 1)) ? '0
                                                             : free_head_reg + 1'b1;

    // Link store: free-list or in-class successor of each node.
    tcpq_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Code store, written on insert and read at the queue head.
    tcpq_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (CAPACITY)
    ) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr (free_head_reg),
        .wdata (code_reg),
        .re    (accept),
        .raddr (head_reg[sel_cls]),
        .rdata (code_rdata)
    );

    // Execute step: update the lists and form the result.
    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        hwm_next        = hwm_reg;
        count_next      = count_reg;
        present_next    = present_reg;
        for (int i = 0; i < NUM_CLS; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end
        done_next       = 1'b0;
        status_next     = status_reg;
        head_code_next  = head_code_reg;
        head_class_next = head_class_reg;
        link_we         = 1'b0;
        link_waddr      = tail_reg[cls_reg];
        link_wdata      = free_head_reg;
        code_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                status_next     = STATUS_OK;
                head_code_next  = '0;
                head_class_next = CLS_VIP;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            code_we = 1'b1;
                            // Chain the new node behind the tail of its class.
                            link_we    = present_reg[cls_reg];
                            link_waddr = tail_reg[cls_reg];
                            link_wdata = free_head_reg;
                            if (!present_reg[cls_reg])
                            begin
                                head_next[cls_reg] = free_head_reg;
                            end
                            tail_next[cls_reg]    = free_head_reg;
                            present_next[cls_reg] = 1'b1;
                            count_next            = count_reg + 1'b1;
                            if (fresh)
                            begin
                                free_head_next = fresh_next;
                                hwm_next       = hwm_reg + 1'b1;
                            end
                            else
                            begin
                                free_head_next = link_rdata;
                            end
                        end
                    end
                    CMD_PEEK, CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            head_code_next  = code_rdata;
                            head_class_next = sel_cls;
                            if (cmd_reg == CMD_POP)
                            begin
                                // Return the head node to the free list.
                                link_we    = 1'b1;
                                link_waddr = head_reg[sel_cls];
                                link_wdata = free_head_reg;
                                free_head_next = head_reg[sel_cls];
                                count_next     = count_reg - 1'b1;
                                if (tail_reg[sel_cls] == head_reg[sel_cls])
                                begin
                                    present_next[sel_cls] = 1'b0;
                                end
                                else
                                begin
                                    head_next[sel_cls] = link_rdata;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            hwm_reg       <= '0;
            count_reg     <= '0;
            present_reg   <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < NUM_CLS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            count_reg     <= count_next;
            present_reg   <= present_next;
            done_reg      <= done_next;
            for (int i = 0; i < NUM_CLS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    // Payload registers: command capture and result fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            code_reg <= item_code;
            cls_reg  <= in_cls;
        end
        status_reg     <= status_next;
        head_code_reg  <= head_code_next;
        head_class_reg <= head_class_next;
    end

endmodule

// File: sim/tcpq_checker.sv
// ----------------------------------------------------------------------------
// tcpq_checker
// Watches the command and result channels of the three-class priority queue.
// It keeps a shadow copy of the linked node store and predicts the result of
// each command transfer. Every result strobe is then compared field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tcpq_checker
    import tcpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int CODE_W   = DEF_CODE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [CMD_W-1:0]              cmd,
    input  logic [CODE_W-1:0]             item_code,
    input  logic [CLS_W-1:0]              item_class,
    input  logic                          done,
    input  logic [STATUS_W-1:0]           status,
    input  logic [CODE_W-1:0]             head_code,
    input  logic [CLS_W-1:0]              head_class,
    input  logic [$clog2(CAPACITY+1)-1:0] occupancy,
    output int unsigned                   mismatches,
    output int unsigned                   pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY+1);

    typedef struct packed {
        status_t           status;
        logic [CODE_W-1:0] code;
        cls_t              cls;
        logic [OCC_W-1:0]  occupancy;
    } queue_result_t;

    // Shadow copy of the node store, the class tails and the free list.
    logic [CODE_W-1:0] shadow_code  [CAPACITY];
    cls_t              shadow_class [CAPACITY];
    logic [IDX_W-1:0]  shadow_link  [CAPACITY];
    logic [IDX_W-1:0]  shadow_head;
    logic [IDX_W-1:0]  shadow_tail  [NUM_CLS];
    logic [NUM_CLS-1:0] shadow_present;
    logic [IDX_W-1:0]  shadow_free;
    logic [OCC_W-1:0]  shadow_count;

    queue_result_t     due_results[$];
    int unsigned       issued;
    int unsigned       received;

    assign pending = issued - received;

    // Applies one command to the shadow queue and returns the result it gives.
    function automatic queue_result_t apply_command(cmd_t c, logic [CODE_W-1:0] code,
                                                    cls_t cls_in);
        queue_result_t    r;
        cls_t             cls;
        cls_t             hc;
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] pred;
        logic             has_pred;
        r        = '0;
        r.status = STATUS_OK;
        // An out-of-range class is treated as normal.
        cls      = (cls_in > CLS_NORMAL) ? CLS_NORMAL : cls_in;
        pred     = '0;
        has_pred = 1'b0;
        case (c)
            CMD_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    node               = shadow_free;
                    shadow_free        = shadow_link[node];
                    shadow_code[node]  = code;
                    shadow_class[node] = cls;
                    // Link behind the own class tail, else behind the nearest
                    // higher class that holds entries.
                    for (int k = int'(cls); k >= 0; k--)
                    begin
                        if (!has_pred && shadow_present[k])
                        begin
                            pred     = shadow_tail[k];
                            has_pred = 1'b1;
                        end
                    end
                    if (has_pred)
                    begin
                        shadow_link[node] = shadow_link[pred];
                        shadow_link[pred] = node;
                    end
                    else
                    begin
                        shadow_link[node] = shadow_head;
                        shadow_head       = node;
                    end
                    shadow_tail[cls]    = node;
                    shadow_present[cls] = 1'b1;
                    shadow_count        = shadow_count + 1'b1;
                end
            end
            CMD_PEEK, CMD_POP:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    node   = shadow_head;
                    hc     = shadow_class[node];
                    r.code = shadow_code[node];
                    r.cls  = hc;
                    if (c == CMD_POP)
                    begin
                        // The last entry of its class leaving clears the class.
                        if (shadow_tail[hc] == node)
                            shadow_present[hc] = 1'b0;
                        shadow_head       = shadow_link[node];
                        shadow_link[node] = shadow_free;
                        shadow_free       = node;
                        shadow_count      = shadow_count - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = shadow_count;
        return r;
    endfunction

    // Reports a failure; only the first ten are printed.
    task automatic note_mismatch(input string what, input queue_result_t exp_r,
                                 input queue_result_t act_r);
        if (mismatches < 10)
            $display("%0t ns: %s: expected status %0d code %h class %0d occ %0d, got status %0d code %h class %0d occ %0d",
                     $time, what, exp_r.status, exp_r.code, exp_r.cls, exp_r.occupancy,
                     act_r.status, act_r.code, act_r.cls, act_r.occupancy);
        mismatches <= mismatches + 1;
    endtask

    // Compare results against predictions, then predict accepted commands.
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t got;
        queue_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                shadow_code[i]  = '0;
                shadow_class[i] = CLS_VIP;
                shadow_link[i]  = IDX_W'((i + 1) % CAPACITY);
            end
            for (int k = 0; k < NUM_CLS; k++)
                shadow_tail[k] = '0;
            shadow_head    = '0;
            shadow_present = '0;
            shadow_free    = '0;
            shadow_count   = '0;
            due_results.delete();
            issued     <= 0;
            received   <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (done)
            begin
                got.status    = status;
                got.code      = head_code;
                got.cls       = head_class;
                got.occupancy = occupancy;
                if (due_results.size() == 0)
                begin
                    note_mismatch("result with no command outstanding", '0, got);
                end
                else
                begin
                    want = due_results.pop_front();
                    received <= received + 1;
                    if (got.status !== want.status || got.code !== want.code ||
                        got.cls !== want.cls || got.occupancy !== want.occupancy)
                        note_mismatch("result mismatch", want, got);
                end
            end
            if (start && !busy)
            begin
                due_results.push_back(apply_command(cmd, item_code, item_class));
                issued <= issued + 1;
            end
        end
    end

endmodule

// File: sim/tb_three_class_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_three_class_priority_queue
// Drives insert, peek and pop commands into the three-class priority queue.
// A short directed sequence covers the empty cases, class ordering and
// out-of-range codes; random phases then fill the queue past full, drain it
// and mix commands with random gaps. The checker gives the failure count.
// ----------------------------------------------------------------------------
module tb_three_class_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import tcpq_pkg::*;

    localparam int   CAPACITY     = DEF_CAPACITY;
    localparam int   CODE_W       = DEF_CODE_BITS;
    localparam int   OCC_W        = $clog2(CAPACITY+1);
    localparam int   RANDOM_ITEMS = 1300;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam cmd_t CMD_NOP      = 2'd3;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    cmd_t              cmd        = CMD_INSERT;
    logic [CODE_W-1:0] item_code  = '0;
    cls_t              item_class = CLS_VIP;
    logic              busy;
    logic              done;
    status_t           status;
    logic [CODE_W-1:0] head_code;
    cls_t              head_class;
    logic [OCC_W-1:0]  occupancy;

    int unsigned       mismatches;
    int unsigned       pending;
    int unsigned       cycle_count = 0;
    int unsigned       sent        = 0;
    logic              burst_mode  = 1'b0;

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    three_class_priority_queue #(
        .CAPACITY  (CAPACITY),
        .CODE_BITS (CODE_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .item_code  (item_code),
        .item_class (item_class),
        .done       (done),
        .status     (status),
        .head_code  (head_code),
        .head_class (head_class),
        .occupancy  (occupancy)
    );

    tcpq_checker #(
        .CAPACITY (CAPACITY),
        .CODE_W   (CODE_W)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .item_code  (item_code),
        .item_class (item_class),
        .done       (done),
        .status     (status),
        .head_code  (head_code),
        .head_class (head_class),
        .occupancy  (occupancy),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Waits the drawn gap, then holds a command until its transfer.
    task automatic send_item(input cmd_t c, input logic [CODE_W-1:0] code, input cls_t cls);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= c;
        item_code  <= code;
        item_class <= cls;
        do @(posedge clk); while (busy);
    endtask

    // Holds off new commands until every outstanding result has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Sends random commands; insert_pct sets the share of inserts.
    task automatic run_phase(input int unsigned insert_pct, input int unsigned count);
        int unsigned       r;
        cmd_t              c;
        cls_t              cls;
        logic [CODE_W-1:0] code;
        for (int unsigned n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < insert_pct)
                c = CMD_INSERT;
            else if (r < 97)
                c = ($urandom_range(9) < 7) ? CMD_POP : CMD_PEEK;
            else
                c = CMD_NOP;
            // Class 3 shows up now and then; it must be stored as normal.
            cls = ($urandom_range(9) == 0) ? cls_t'(2'd3) : cls_t'($urandom_range(2));
            case ($urandom_range(15))
                0:       code = '0;
                1:       code = '1;
                default: code = CODE_W'($urandom());
            endcase
            send_item(c, code, cls);
            sent++;
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        int unsigned kind;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, class order, out-of-range class and command.
        send_item(CMD_PEEK,   16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'hFFFF, CLS_NORMAL);
        send_item(CMD_NOP,    16'hFFFF, cls_t'(2'd3));
        send_item(CMD_INSERT, 16'h0000, CLS_NORMAL);
        send_item(CMD_INSERT, 16'hFFFF, cls_t'(2'd3));
        send_item(CMD_INSERT, 16'h1234, CLS_CLIENT);
        send_item(CMD_INSERT, 16'hFFFF, CLS_VIP);
        send_item(CMD_INSERT, 16'h8001, CLS_VIP);
        send_item(CMD_INSERT, 16'h7FFE, CLS_CLIENT);
        send_item(CMD_PEEK,   16'h0000, CLS_VIP);
        send_item(CMD_NOP,    16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        // The VIP class is empty again, so this entry goes to the head.
        send_item(CMD_INSERT, 16'h00FF, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_INSERT, 16'h5A5A, CLS_CLIENT);
        send_item(CMD_PEEK,   16'hFFFF, CLS_NORMAL);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_POP,    16'h0000, CLS_VIP);
        send_item(CMD_PEEK,   16'h0000, CLS_VIP);

        // Fill past capacity first so that full drops are seen early.
        run_phase(95, 80);
        wait_for_results();

        // Random phases: balanced, fill-heavy and drain-heavy mixes.
        while (sent < RANDOM_ITEMS)
        begin
            burst_mode = ($urandom_range(3) == 0);
            kind       = $urandom_range(2);
            case (kind)
                0:       run_phase(55, $urandom_range(40, 120));
                1:       run_phase(90, $urandom_range(40, 120));
                default: run_phase(15, $urandom_range(40, 120));
            endcase
            if ($urandom_range(2) == 0)
                wait_for_results();
        end

        // Let the last results arrive, then allow a few quiet cycles.
        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
hdl/tcpq_pkg.sv
hdl/tcpq_ram.sv
hdl/three_class_priority_queue.sv
sim/tcpq_checker.sv
sim/tb_three_class_priority_queue.sv
